// File: sv/tga_pkg.sv
// Shared types, codes and helpers of the TGA RLE image decoder.
package tga_pkg;

  // Decoder phases.
  localparam logic [2:0] PH_TYPE   = 3'd0;
  localparam logic [2:0] PH_INFO   = 3'd1;
  localparam logic [2:0] PH_UNCOMP = 3'd2;
  localparam logic [2:0] PH_PKT    = 3'd3;
  localparam logic [2:0] PH_RAW    = 3'd4;
  localparam logic [2:0] PH_RUN    = 3'd5;
  localparam logic [2:0] PH_DONE   = 3'd6;
  localparam logic [2:0] PH_ERROR  = 3'd7;

  // Result status codes.
  localparam logic [2:0] STAT_PIXELS    = 3'd0;
  localparam logic [2:0] STAT_COMPLETE  = 3'd1;
  localparam logic [2:0] STAT_BAD_TYPE  = 3'd2;
  localparam logic [2:0] STAT_BAD_INFO  = 3'd3;
  localparam logic [2:0] STAT_TOO_MANY  = 3'd4;
  localparam logic [2:0] STAT_EARLY_END = 3'd5;

  // Header layout and accepted formats.
  localparam logic [3:0] TYPE_HDR_LAST  = 4'd11;
  localparam logic [3:0] TYPE_CODE_POS  = 4'd2;
  localparam logic [7:0] TYPE_UNCOMP    = 8'd2;
  localparam logic [7:0] TYPE_RLE       = 8'd10;
  localparam logic [3:0] INFO_WIDTH_LO  = 4'd0;
  localparam logic [3:0] INFO_WIDTH_HI  = 4'd1;
  localparam logic [3:0] INFO_HEIGHT_LO = 4'd2;
  localparam logic [3:0] INFO_HEIGHT_HI = 4'd3;
  localparam logic [3:0] INFO_BPP       = 4'd4;
  localparam logic [3:0] INFO_LAST      = 4'd5;
  localparam logic [7:0] BPP_RGB        = 8'd24;
  localparam logic [7:0] BPP_RGBA       = 8'd32;
  localparam logic [7:0] RUN_BIAS       = 8'd127;

  typedef struct packed {
    logic take;      // input item accepted this cycle
    logic run_step;  // emit the next pixel pair of a run
  } tga_cmd_t;

  typedef struct packed {
    logic res_valid;  // the accepted item yields a result now
    logic run_start;  // the accepted item completed a run pixel
    logic run_last;   // the next run step is the final one
  } tga_stat_t;

  // Exchange the blue and red bytes of a pixel.
  function automatic logic [31:0] swap_rb(input logic [31:0] p);
    return {p[31:24], p[7:0], p[15:8], p[23:16]};
  endfunction

endpackage

// File: sv/tga_stream_if.sv
// Handshake channels of the TGA decoder: file bytes in, pixel results out.
interface tga_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       end_of_file;

  modport source (output valid, output file_byte, output end_of_file, input ready);
  modport sink (input valid, input file_byte, input end_of_file, output ready);
endinterface

interface tga_pix_if;
  logic        valid;
  logic        ready;
  logic [31:0] first_pixel;
  logic [31:0] second_pixel;
  logic [1:0]  pixel_count;
  logic [31:0] first_index;
  logic [2:0]  status;
  logic        last_of_run;

  modport source (output valid, output first_pixel, output second_pixel,
                  output pixel_count, output first_index, output status,
                  output last_of_run, input ready);
  modport sink (input valid, input first_pixel, input second_pixel,
                input pixel_count, input first_index, input status,
                input last_of_run, output ready);
endinterface

// File: sv/tga_dp.sv
// Datapath of the TGA decoder: header parsing, pixel assembly and result register.
module tga_dp (
  input  logic               clk,
  input  logic               rst,
  input  tga_pkg::tga_cmd_t  cmd,
  output tga_pkg::tga_stat_t st,
  input  logic [7:0]         file_byte,
  input  logic               end_of_file,
  output logic [31:0]        first_pixel,
  output logic [31:0]        second_pixel,
  output logic [1:0]         pixel_count,
  output logic [31:0]        first_index,
  output logic [2:0]         status,
  output logic               last_of_run
);

  logic [2:0]  phase, phase_next;
  logic [3:0]  hdr_pos, hdr_pos_next;
  logic [1:0]  hdr_match, hdr_match_next;
  logic [15:0] img_width, img_width_next;
  logic [15:0] img_height, img_height_next;
  logic        four_bpp, four_bpp_next;
  logic [31:0] pix_total, pix_total_next;
  logic [31:0] pix_done, pix_done_next;
  logic [7:0]  pkt_left, pkt_left_next;
  logic [1:0]  byte_idx, byte_idx_next;
  logic [31:0] pix_asm, pix_asm_next;
  logic [31:0] run_px, run_px_next;
  logic        run_eof, run_eof_next;

  logic [31:0] r_first, r_second, r_index;
  logic [1:0]  r_count;
  logic [2:0]  r_status;
  logic        r_last;
  logic        res_valid, run_start, clear;

  logic [31:0] asm_new, done_inc, done_step, remain;
  logic [1:0]  idx_inc, step;
  logic        px_done;
  logic [7:0]  cnt;

  assign asm_new   = pix_asm | (32'(file_byte) << {byte_idx, 3'b000});
  assign idx_inc   = byte_idx + 2'd1;
  assign px_done   = four_bpp ? (idx_inc == 2'd0) : (idx_inc == 2'd3);
  assign done_inc  = pix_done + 32'd1;
  assign cnt       = file_byte[7] ? (file_byte - tga_pkg::RUN_BIAS) : (file_byte + 8'd1);
  assign remain    = pix_total - pix_done;
  assign step      = (pkt_left >= 8'd2) ? 2'd2 : 2'd1;
  assign done_step = pix_done + 32'(step);

  always_comb begin
    phase_next      = phase;
    hdr_pos_next    = hdr_pos;
    hdr_match_next  = hdr_match;
    img_width_next  = img_width;
    img_height_next = img_height;
    four_bpp_next   = four_bpp;
    pix_total_next  = pix_total;
    pix_done_next   = pix_done;
    pkt_left_next   = pkt_left;
    byte_idx_next   = byte_idx;
    pix_asm_next    = pix_asm;
    run_px_next     = run_px;
    run_eof_next    = run_eof;
    r_first   = '0;
    r_second  = '0;
    r_count   = '0;
    r_index   = '0;
    r_status  = tga_pkg::STAT_PIXELS;
    r_last    = 1'b1;
    res_valid = 1'b0;
    run_start = 1'b0;
    clear     = 1'b0;

    if (cmd.take) begin
      unique case (phase) inside
        tga_pkg::PH_TYPE: begin
          if (file_byte != ((hdr_pos == tga_pkg::TYPE_CODE_POS) ? tga_pkg::TYPE_UNCOMP : 8'd0))
            hdr_match_next[0] = 1'b0;
          if (file_byte != ((hdr_pos == tga_pkg::TYPE_CODE_POS) ? tga_pkg::TYPE_RLE : 8'd0))
            hdr_match_next[1] = 1'b0;
          hdr_pos_next = hdr_pos + 4'd1;
          if (hdr_pos == tga_pkg::TYPE_HDR_LAST) begin
            hdr_pos_next = '0;
            if (hdr_match_next == 2'b00) begin
              res_valid  = 1'b1;
              r_status   = tga_pkg::STAT_BAD_TYPE;
              phase_next = tga_pkg::PH_ERROR;
            end else begin
              phase_next = tga_pkg::PH_INFO;
            end
          end
        end
        tga_pkg::PH_INFO: begin
          case (hdr_pos)
            tga_pkg::INFO_WIDTH_LO:  img_width_next  = {8'h00, file_byte};
            tga_pkg::INFO_WIDTH_HI:  img_width_next  = {file_byte, img_width[7:0]};
            tga_pkg::INFO_HEIGHT_LO: img_height_next = {8'h00, file_byte};
            tga_pkg::INFO_HEIGHT_HI: img_height_next = {file_byte, img_height[7:0]};
            tga_pkg::INFO_BPP:       pix_asm_next    = {24'h0, file_byte};
            default: ;
          endcase
          hdr_pos_next = hdr_pos + 4'd1;
          if (hdr_pos == tga_pkg::INFO_LAST) begin
            hdr_pos_next  = '0;
            pix_asm_next  = '0;
            byte_idx_next = '0;
            if (img_width == 16'd0 || img_height == 16'd0 ||
                (pix_asm[7:0] != tga_pkg::BPP_RGB && pix_asm[7:0] != tga_pkg::BPP_RGBA)) begin
              res_valid  = 1'b1;
              r_status   = tga_pkg::STAT_BAD_INFO;
              phase_next = tga_pkg::PH_ERROR;
            end else begin
              four_bpp_next  = (pix_asm[7:0] == tga_pkg::BPP_RGBA);
              pix_total_next = {16'h0, img_width} * {16'h0, img_height};
              pix_done_next  = '0;
              phase_next     = hdr_match[0] ? tga_pkg::PH_UNCOMP : tga_pkg::PH_PKT;
            end
          end
        end
        tga_pkg::PH_PKT: begin
          if ({24'h0, cnt} > remain) begin
            res_valid  = 1'b1;
            r_status   = tga_pkg::STAT_TOO_MANY;
            phase_next = tga_pkg::PH_ERROR;
          end else begin
            pkt_left_next = cnt;
            byte_idx_next = '0;
            pix_asm_next  = '0;
            phase_next    = file_byte[7] ? tga_pkg::PH_RUN : tga_pkg::PH_RAW;
          end
        end
        tga_pkg::PH_UNCOMP, tga_pkg::PH_RAW, tga_pkg::PH_RUN: begin
          if (px_done) begin
            pix_asm_next  = '0;
            byte_idx_next = '0;
            if (phase == tga_pkg::PH_RUN) begin
              run_px_next  = tga_pkg::swap_rb(asm_new);
              run_eof_next = end_of_file;
              run_start    = 1'b1;
            end else begin
              res_valid     = 1'b1;
              r_count       = 2'd1;
              r_index       = pix_done;
              r_first       = (phase == tga_pkg::PH_RAW) ? tga_pkg::swap_rb(asm_new) : asm_new;
              pix_done_next = done_inc;
              if (phase == tga_pkg::PH_UNCOMP) begin
                if (done_inc == pix_total) begin
                  r_status   = tga_pkg::STAT_COMPLETE;
                  phase_next = tga_pkg::PH_DONE;
                end
              end else begin
                pkt_left_next = (pkt_left == 8'd0) ? 8'd0 : pkt_left - 8'd1;
                if (pkt_left <= 8'd1) begin
                  if (done_inc == pix_total) begin
                    r_status   = tga_pkg::STAT_COMPLETE;
                    phase_next = tga_pkg::PH_DONE;
                  end else begin
                    phase_next = tga_pkg::PH_PKT;
                  end
                end
              end
            end
          end else begin
            pix_asm_next  = asm_new;
            byte_idx_next = idx_inc;
          end
        end
        default: ;
      endcase

      // A run pixel defers end-of-file handling to its final pixel pair.
      if (end_of_file && !run_start) begin
        if (phase_next != tga_pkg::PH_DONE && phase_next != tga_pkg::PH_ERROR) begin
          if (!res_valid) begin
            res_valid = 1'b1;
            r_status  = tga_pkg::STAT_EARLY_END;
          end else if (r_status == tga_pkg::STAT_PIXELS) begin
            r_status = tga_pkg::STAT_EARLY_END;
          end
        end
        clear = 1'b1;
      end
    end else if (cmd.run_step) begin
      r_first       = run_px;
      r_second      = (step == 2'd2) ? run_px : 32'd0;
      r_count       = step;
      r_index       = pix_done;
      r_last        = (pkt_left <= 8'd2);
      pix_done_next = done_step;
      pkt_left_next = pkt_left - 8'(step);
      if (pkt_left <= 8'd2) begin
        pkt_left_next = '0;
        if (done_step == pix_total) begin
          r_status   = tga_pkg::STAT_COMPLETE;
          phase_next = tga_pkg::PH_DONE;
        end else begin
          phase_next = tga_pkg::PH_PKT;
        end
        if (run_eof) begin
          if (r_status == tga_pkg::STAT_PIXELS) r_status = tga_pkg::STAT_EARLY_END;
          clear = 1'b1;
        end
      end
    end

    if (clear) begin
      phase_next      = tga_pkg::PH_TYPE;
      hdr_pos_next    = '0;
      hdr_match_next  = 2'b11;
      img_width_next  = '0;
      img_height_next = '0;
      four_bpp_next   = 1'b0;
      pix_total_next  = '0;
      pix_done_next   = '0;
      pkt_left_next   = '0;
      byte_idx_next   = '0;
      pix_asm_next    = '0;
      run_eof_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= tga_pkg::PH_TYPE;
      hdr_pos    <= '0;
      hdr_match  <= 2'b11;
      img_width  <= '0;
      img_height <= '0;
      four_bpp   <= 1'b0;
      pix_total  <= '0;
      pix_done   <= '0;
      pkt_left   <= '0;
      byte_idx   <= '0;
      pix_asm    <= '0;
      run_eof    <= 1'b0;
    end else begin
      phase      <= phase_next;
      hdr_pos    <= hdr_pos_next;
      hdr_match  <= hdr_match_next;
      img_width  <= img_width_next;
      img_height <= img_height_next;
      four_bpp   <= four_bpp_next;
      pix_total  <= pix_total_next;
      pix_done   <= pix_done_next;
      pkt_left   <= pkt_left_next;
      byte_idx   <= byte_idx_next;
      pix_asm    <= pix_asm_next;
      run_eof    <= run_eof_next;
    end
  end

  always_ff @(posedge clk) begin
    run_px <= run_px_next;
    if (cmd.run_step || (cmd.take && res_valid)) begin
      first_pixel  <= r_first;
      second_pixel <= r_second;
      pixel_count  <= r_count;
      first_index  <= r_index;
      status       <= r_status;
      last_of_run  <= r_last;
    end
  end

  assign st.res_valid = res_valid;
  assign st.run_start = run_start;
  assign st.run_last  = (pkt_left <= 8'd2);

endmodule

// File: sv/tga_ctrl.sv
// Controller of the TGA decoder: input/output handshake and run expansion sequencing.
module tga_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  tga_pkg::tga_stat_t st,
  output tga_pkg::tga_cmd_t  cmd
);

  localparam logic ST_ACCEPT = 1'b0;
  localparam logic ST_RUN    = 1'b1;

  logic state, state_next;
  logic out_free;

  assign out_free     = !out_valid || out_ready;
  assign in_ready     = (state == ST_ACCEPT) && out_free;
  assign cmd.take     = in_valid && in_ready;
  assign cmd.run_step = (state == ST_RUN) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_ACCEPT: if (cmd.take && st.run_start) state_next = ST_RUN;
      ST_RUN:    if (cmd.run_step && st.run_last) state_next = ST_ACCEPT;
      default:   state_next = ST_ACCEPT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACCEPT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_free) out_valid <= (cmd.take && st.res_valid) || cmd.run_step;
    end
  end

  // A run pixel always starts the expansion sequence.
  a_run_enter: assert property (@(posedge clk) disable iff (rst)
    cmd.take && st.run_start |=> state == ST_RUN)
    else $error("run pixel did not start expansion");

  // Expansion ends only on its final pair.
  a_run_hold: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN && !(cmd.run_step && st.run_last) |=> state == ST_RUN)
    else $error("run expansion left early");

  // A byte that yields a result shows it on the next cycle.
  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.take && st.res_valid |=> out_valid)
    else $error("result of accepted item was lost");

endmodule

// File: sv/tga_rle_image_decoder_unit.sv
// Top level of the TGA image decoder (uncompressed and RLE true-color files).
//
// The file_bytes channel carries the file one byte per item, from its first
// header byte; end_of_file marks the final byte, after which the decoder
// restarts for the next file. The results channel carries up to two pixels
// per item with the raster index of the first, plus a status code that flags
// image complete, a bad type header, bad image info, too many pixels or an
// early end of file. last_of_run marks the final result caused by one byte.
// A header, raw or uncompressed byte that completes a pixel or a status is
// visible in the output register on the cycle after it is accepted. Header,
// raw packet and uncompressed bytes are taken one per cycle while the receiver
// does not stall. A byte that completes the pixel of a run packet holds the
// input off while the run drains as pixel pairs, one pair per cycle while the
// receiver does not stall: the controller's state register enters the run
// state after the byte, and each pair is then loaded into the output register.
// When the receiver stalls, the output register holds its item and no new
// byte is accepted until that item is taken. Synchronous reset returns the
// decoder to the start of the type header and empties the output register;
// there is no clearing pass, so the first byte may be sent right after reset.
module tga_rle_image_decoder_unit (
  input logic      clk,
  input logic      rst,
  tga_byte_if.sink file_bytes,
  tga_pix_if.source results
);

  tga_pkg::tga_cmd_t  cmd;
  tga_pkg::tga_stat_t st;

  // Handshake and run sequencing.
  tga_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (file_bytes.valid),
    .in_ready  (file_bytes.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Header parsing, pixel assembly, counters and the result register.
  tga_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .file_byte    (file_bytes.file_byte),
    .end_of_file  (file_bytes.end_of_file),
    .first_pixel  (results.first_pixel),
    .second_pixel (results.second_pixel),
    .pixel_count  (results.pixel_count),
    .first_index  (results.first_index),
    .status       (results.status),
    .last_of_run  (results.last_of_run)
  );

endmodule

// File: verif/tga_decode_checker.sv
// Checker that predicts the decoder's results from the accepted file bytes and compares them.
`timescale 1ns / 100ps

module tga_decode_checker (
  input  logic clk,
  input  logic rst,
  tga_byte_if  file_bytes,
  tga_pix_if   results,
  output int   pending,
  output int   error_count
);

  typedef struct packed {
    logic [31:0] first_pixel;
    logic [31:0] second_pixel;
    logic [1:0]  pixel_count;
    logic [31:0] first_index;
    logic [2:0]  status;
    logic        last_of_run;
  } pix_item_t;

  // Predicted decoder state.
  logic [2:0]  dec_phase;
  logic [4:0]  hdr_pos;
  logic [1:0]  hdr_match;
  logic [15:0] img_w;
  logic [15:0] img_h;
  logic        wide_pixel;
  logic [31:0] px_total;
  logic [31:0] px_done;
  logic [7:0]  pkt_left;
  logic [1:0]  px_byte;
  logic [31:0] px_accum;

  pix_item_t predicted_results[$];
  pix_item_t byte_results [0:71];
  int        byte_result_n;
  int        fails = 0;

  assign error_count = fails;
  assign pending     = predicted_results.size();

  function automatic logic [31:0] exchange_blue_red(input logic [31:0] p);
    logic [31:0] q;
    q = p;
    q[7:0]   = p[23:16];
    q[23:16] = p[7:0];
    return q;
  endfunction

  task automatic clear_decoder();
    dec_phase  = tga_pkg::PH_TYPE;
    hdr_pos    = '0;
    hdr_match  = 2'b11;
    img_w      = '0;
    img_h      = '0;
    wide_pixel = 1'b0;
    px_total   = '0;
    px_done    = '0;
    pkt_left   = '0;
    px_byte    = '0;
    px_accum   = '0;
  endtask

  task automatic add_result(input logic [31:0] p0, input logic [31:0] p1,
                            input logic [1:0] cnt, input logic [31:0] idx,
                            input logic [2:0] st);
    byte_results[byte_result_n].first_pixel  = p0;
    byte_results[byte_result_n].second_pixel = p1;
    byte_results[byte_result_n].pixel_count  = cnt;
    byte_results[byte_result_n].first_index  = idx;
    byte_results[byte_result_n].status       = st;
    byte_results[byte_result_n].last_of_run  = 1'b0;
    byte_result_n++;
  endtask

  task automatic close_packet();
    if (px_done == px_total) begin
      byte_results[byte_result_n - 1].status = tga_pkg::STAT_COMPLETE;
      dec_phase = tga_pkg::PH_DONE;
    end else begin
      dec_phase = tga_pkg::PH_PKT;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eof);
    logic [7:0]  want_uncomp;
    logic [7:0]  want_rle;
    logic [7:0]  bpp;
    logic [8:0]  pkt_len;
    logic [31:0] pix;
    int          run_left;
    byte_result_n = 0;
    case (dec_phase)
      tga_pkg::PH_TYPE: begin
        want_uncomp = (hdr_pos == tga_pkg::TYPE_CODE_POS) ? tga_pkg::TYPE_UNCOMP : 8'd0;
        want_rle    = (hdr_pos == tga_pkg::TYPE_CODE_POS) ? tga_pkg::TYPE_RLE : 8'd0;
        if (b != want_uncomp) hdr_match[0] = 1'b0;
        if (b != want_rle) hdr_match[1] = 1'b0;
        hdr_pos = hdr_pos + 5'd1;
        if (hdr_pos > tga_pkg::TYPE_HDR_LAST) begin
          hdr_pos = '0;
          if (hdr_match == 2'b00) begin
            add_result('0, '0, 2'd0, '0, tga_pkg::STAT_BAD_TYPE);
            dec_phase = tga_pkg::PH_ERROR;
          end else begin
            dec_phase = tga_pkg::PH_INFO;
          end
        end
      end
      tga_pkg::PH_INFO: begin
        case (hdr_pos)
          tga_pkg::INFO_WIDTH_LO:  img_w = {8'd0, b};
          tga_pkg::INFO_WIDTH_HI:  img_w[15:8] = b;
          tga_pkg::INFO_HEIGHT_LO: img_h = {8'd0, b};
          tga_pkg::INFO_HEIGHT_HI: img_h[15:8] = b;
          tga_pkg::INFO_BPP:       px_accum = {24'd0, b};
          default: ;
        endcase
        hdr_pos = hdr_pos + 5'd1;
        if (hdr_pos > tga_pkg::INFO_LAST) begin
          bpp      = px_accum[7:0];
          hdr_pos  = '0;
          px_accum = '0;
          px_byte  = '0;
          if (img_w == 16'd0 || img_h == 16'd0 ||
              (bpp != tga_pkg::BPP_RGB && bpp != tga_pkg::BPP_RGBA)) begin
            add_result('0, '0, 2'd0, '0, tga_pkg::STAT_BAD_INFO);
            dec_phase = tga_pkg::PH_ERROR;
          end else begin
            wide_pixel = (bpp == tga_pkg::BPP_RGBA);
            px_total   = 32'(img_w) * 32'(img_h);
            px_done    = '0;
            dec_phase  = hdr_match[0] ? tga_pkg::PH_UNCOMP : tga_pkg::PH_PKT;
          end
        end
      end
      tga_pkg::PH_PKT: begin
        // A packet header below 128 starts a raw packet, otherwise a run.
        if (!b[7]) pkt_len = {1'b0, b} + 9'd1;
        else       pkt_len = {1'b0, b} - 9'(tga_pkg::RUN_BIAS);
        if ({23'd0, pkt_len} > px_total - px_done) begin
          add_result('0, '0, 2'd0, '0, tga_pkg::STAT_TOO_MANY);
          dec_phase = tga_pkg::PH_ERROR;
        end else begin
          pkt_left  = pkt_len[7:0];
          px_byte   = '0;
          px_accum  = '0;
          dec_phase = b[7] ? tga_pkg::PH_RUN : tga_pkg::PH_RAW;
        end
      end
      tga_pkg::PH_UNCOMP, tga_pkg::PH_RAW, tga_pkg::PH_RUN: begin
        px_accum = px_accum | (32'(b) << {px_byte, 3'b000});
        px_byte  = px_byte + 2'd1;
        if (px_byte == 2'd0 || (!wide_pixel && px_byte == 2'd3)) begin
          pix      = px_accum;
          px_accum = '0;
          px_byte  = '0;
          if (dec_phase == tga_pkg::PH_UNCOMP) begin
            add_result(pix, '0, 2'd1, px_done, tga_pkg::STAT_PIXELS);
            px_done = px_done + 32'd1;
            if (px_done == px_total) begin
              byte_results[byte_result_n - 1].status = tga_pkg::STAT_COMPLETE;
              dec_phase = tga_pkg::PH_DONE;
            end
          end else if (dec_phase == tga_pkg::PH_RAW) begin
            add_result(exchange_blue_red(pix), '0, 2'd1, px_done, tga_pkg::STAT_PIXELS);
            px_done = px_done + 32'd1;
            if (pkt_left != 8'd0) pkt_left = pkt_left - 8'd1;
            if (pkt_left == 8'd0) close_packet();
          end else begin
            // A run drains as pixel pairs, with a single pixel at an odd end.
            pix      = exchange_blue_red(pix);
            run_left = int'(pkt_left);
            while (run_left > 0) begin
              if (run_left >= 2) begin
                add_result(pix, pix, 2'd2, px_done, tga_pkg::STAT_PIXELS);
                px_done  = px_done + 32'd2;
                run_left = run_left - 2;
              end else begin
                add_result(pix, '0, 2'd1, px_done, tga_pkg::STAT_PIXELS);
                px_done  = px_done + 32'd1;
                run_left = 0;
              end
            end
            pkt_left = '0;
            close_packet();
          end
        end
      end
      default: ;
    endcase

    if (eof) begin
      if (dec_phase != tga_pkg::PH_DONE && dec_phase != tga_pkg::PH_ERROR) begin
        if (byte_result_n > 0 &&
            byte_results[byte_result_n - 1].status == tga_pkg::STAT_PIXELS)
          byte_results[byte_result_n - 1].status = tga_pkg::STAT_EARLY_END;
        else
          add_result('0, '0, 2'd0, '0, tga_pkg::STAT_EARLY_END);
      end
      clear_decoder();
    end

    if (byte_result_n > 0) byte_results[byte_result_n - 1].last_of_run = 1'b1;
    for (int i = 0; i < byte_result_n; i++) predicted_results.push_back(byte_results[i]);
  endtask

  always @(posedge clk) begin
    pix_item_t want;
    pix_item_t got;
    if (rst) begin
      clear_decoder();
      predicted_results.delete();
    end else begin
      if (results.valid && results.ready) begin
        got.first_pixel  = results.first_pixel;
        got.second_pixel = results.second_pixel;
        got.pixel_count  = results.pixel_count;
        got.first_index  = results.first_index;
        got.status       = results.status;
        got.last_of_run  = results.last_of_run;
        if (predicted_results.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected result pix0=%h pix1=%h count=%0d index=%0d status=%0d last=%b",
                     $realtime, got.first_pixel, got.second_pixel, got.pixel_count,
                     got.first_index, got.status, got.last_of_run);
        end else begin
          want = predicted_results.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected pix0=%h pix1=%h count=%0d index=%0d status=%0d last=%b",
                       want.first_pixel, want.second_pixel, want.pixel_count,
                       want.first_index, want.status, want.last_of_run);
              $display("  actual   pix0=%h pix1=%h count=%0d index=%0d status=%0d last=%b",
                       got.first_pixel, got.second_pixel, got.pixel_count,
                       got.first_index, got.status, got.last_of_run);
            end
          end
        end
      end
      if (file_bytes.valid && file_bytes.ready)
        decode_byte(file_bytes.file_byte, file_bytes.end_of_file);
    end
  end

endmodule

// File: verif/tga_rle_image_decoder_unit_test.sv
// Top of the decoder testbench: builds TGA files as byte streams, drives them and gives the verdict.
`timescale 1ns / 100ps

module tga_rle_image_decoder_unit_test;

  // The slowest legal byte is a 128-pixel run, whose 64 results may each wait out a
  // receiver stall. A few hundred bytes then stay well below a quarter of this bound.
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_BYTES = 170;
  // Once more than this many random bytes have gone out, both sides stop idling.
  localparam int QUIET_AFTER  = 130;
  // An extra wait after the last predicted result is taken leaves a comfortable margin.
  localparam int DRAIN_CYCLES = 10;

  // Kinds of file made by the random part of the run.
  typedef enum logic [2:0] {
    FILE_BAD_TYPE,
    FILE_BAD_INFO,
    FILE_HUGE,
    FILE_OVERFLOW,
    FILE_GOOD
  } file_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  int   pending;
  int   error_count;
  int   bytes_sent = 0;
  bit   quiet = 1'b0;        // no idling on either side
  bit   sender_gaps = 1'b0;  // random gaps between bytes of the current file
  logic [7:0] file_q[$];

  tga_byte_if file_bytes();
  tga_pix_if  results();

  tga_rle_image_decoder_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .file_bytes (file_bytes),
    .results    (results)
  );

  tga_decode_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .file_bytes  (file_bytes),
    .results     (results),
    .pending     (pending),
    .error_count (error_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Safety net: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // The receiver alternates random stall bursts with ready stretches, and stops stalling once quiet is set.
  // It changes ready only at falling edges, so the block sees it stable at each rising edge.
  initial begin
    results.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        results.ready = 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk);
      end
      results.ready = 1'b1;
      repeat ($urandom_range(0, 15)) @(negedge clk);
    end
  end

  // Offers one item and returns at the rising edge where the block accepts it. A gap, when
  // taken, lowers valid first; otherwise valid stays high across items.
  task automatic send_byte(input logic [7:0] b, input logic eof);
    if (!quiet && sender_gaps && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      file_bytes.valid = 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clk);
    end
    @(negedge clk);
    file_bytes.valid       = 1'b1;
    file_bytes.file_byte   = b;
    file_bytes.end_of_file = eof;
    do @(posedge clk); while (!file_bytes.ready);
  endtask

  // Sends the first len bytes of the built file, with end_of_file on the last one sent.
  task automatic send_file(input int len);
    for (int i = 0; i < len; i++) send_byte(file_q[i], i == len - 1);
    bytes_sent += len;
  endtask

  // Holds the sender off until every predicted result has been taken.
  task automatic wait_drained();
    do begin
      @(negedge clk);
      file_bytes.valid = 1'b0;
    end while (pending != 0);
  endtask

  task automatic put_type_header(input logic [7:0] code);
    file_q.delete();
    for (int i = 0; i < 12; i++)
      file_q.push_back((i == tga_pkg::TYPE_CODE_POS) ? code : 8'd0);
  endtask

  // Width and height go low byte first; the descriptor byte is random since it is ignored.
  task automatic put_info(input logic [15:0] w, input logic [15:0] h, input logic [7:0] bpp);
    file_q.push_back(w[7:0]);
    file_q.push_back(w[15:8]);
    file_q.push_back(h[7:0]);
    file_q.push_back(h[15:8]);
    file_q.push_back(bpp);
    file_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic put_pixel(input int nbytes);
    repeat (nbytes) file_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // Random raw and run packets that cover exactly total pixels. With overflow set, the
  // body stops at a random point with a packet longer than the pixels still missing.
  task automatic put_rle_body(input int total, input int nbytes, input bit overflow);
    int remaining;
    int len;
    remaining = total;
    while (remaining > 0 && !(overflow && $urandom_range(0, 2) == 0)) begin
      len = $urandom_range(1, (remaining < 128) ? remaining : 128);
      if ($urandom_range(0, 1) == 1) begin
        file_q.push_back(8'(int'(tga_pkg::RUN_BIAS) + len));
        put_pixel(nbytes);
      end else begin
        file_q.push_back(8'(len - 1));
        repeat (len) put_pixel(nbytes);
      end
      remaining -= len;
    end
    if (overflow) begin
      len = $urandom_range(remaining + 1, 128);
      if ($urandom_range(0, 1) == 1) file_q.push_back(8'(int'(tga_pkg::RUN_BIAS) + len));
      else file_q.push_back(8'(len - 1));
      put_pixel(nbytes);
    end
  endtask

  // Builds and sends one random file. Most files are well formed with random content so
  // that decoding gets past the headers; the rest break the header, the image info, the
  // packet sizes, or stop early.
  task automatic random_file();
    file_kind_t  kind;
    int          roll;
    int          nbytes;
    int          len;
    int          pos;
    logic [7:0]  code;
    logic [7:0]  bpp;
    logic [15:0] w;
    logic [15:0] h;
    roll = $urandom_range(0, 19);
    if (roll < 2)       kind = FILE_BAD_TYPE;
    else if (roll < 4)  kind = FILE_BAD_INFO;
    else if (roll == 4) kind = FILE_HUGE;
    else if (roll < 7)  kind = FILE_OVERFLOW;
    else                kind = FILE_GOOD;
    code   = ($urandom_range(0, 1) == 1 || kind == FILE_OVERFLOW) ?
             tga_pkg::TYPE_RLE : tga_pkg::TYPE_UNCOMP;
    nbytes = ($urandom_range(0, 1) == 1) ? 4 : 3;
    bpp    = (nbytes == 4) ? tga_pkg::BPP_RGBA : tga_pkg::BPP_RGB;
    w      = 16'($urandom_range(1, 5));
    h      = 16'($urandom_range(1, 4));
    put_type_header(code);
    case (kind)
      FILE_BAD_TYPE: begin
        // One header byte is changed, mostly to a bad type; after a bad type the rest must be ignored.
        pos = $urandom_range(0, 11);
        if ($urandom_range(0, 1) == 1) file_q[pos] = 8'($urandom_range(1, 255));
        else file_q[pos] = file_q[pos] ^ (8'd1 << $urandom_range(0, 7));
        put_info(w, h, bpp);
        put_pixel($urandom_range(0, 6));
      end
      FILE_BAD_INFO: begin
        case ($urandom_range(0, 2))
          0: w = '0;
          1: h = '0;
          default: begin
            bpp = 8'($urandom_range(0, 255));
            if (bpp == tga_pkg::BPP_RGB || bpp == tga_pkg::BPP_RGBA) bpp = 8'd16;
          end
        endcase
        put_info(w, h, bpp);
        put_pixel($urandom_range(0, 6));
      end
      FILE_HUGE: begin
        // Very large images, cut off after a few long runs or pixels.
        w = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'($urandom_range(256, 65535));
        h = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'($urandom_range(1, 65535));
        put_info(w, h, bpp);
        if (code == tga_pkg::TYPE_RLE) begin
          repeat (3) begin
            file_q.push_back(8'(int'(tga_pkg::RUN_BIAS) + $urandom_range(96, 128)));
            put_pixel(nbytes);
          end
          file_q.push_back(8'd1);
          repeat (2) put_pixel(nbytes);
        end else begin
          repeat ($urandom_range(1, 4)) put_pixel(nbytes);
        end
      end
      FILE_OVERFLOW: begin
        put_info(w, h, bpp);
        put_rle_body(int'(w) * int'(h), nbytes, 1'b1);
      end
      default: begin
        put_info(w, h, bpp);
        if (code == tga_pkg::TYPE_RLE) put_rle_body(int'(w) * int'(h), nbytes, 1'b0);
        else repeat (int'(w) * int'(h)) put_pixel(nbytes);
        // Bytes after a complete image are ignored by the block.
        if ($urandom_range(0, 3) == 0) put_pixel($urandom_range(1, 4));
      end
    endcase
    len = file_q.size();
    // Some good files are cut short, anywhere from the type header to their last byte.
    if (kind == FILE_GOOD && $urandom_range(0, 4) == 0) len = $urandom_range(1, len - 1);
    send_file(len);
  endtask

  initial begin
    file_bytes.valid       = 1'b0;
    file_bytes.file_byte   = '0;
    file_bytes.end_of_file = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: a 128 x 1 RLE image made of one maximal run, which drains as 64 pixel
    // pairs; the last pair also reports the image complete.
    sender_gaps = 1'b1;
    put_type_header(tga_pkg::TYPE_RLE);
    put_info(16'd128, 16'd1, tga_pkg::BPP_RGB);
    file_q.push_back(8'hFF);
    file_q.push_back(8'h00);
    file_q.push_back(8'h80);
    file_q.push_back(8'hFF);
    send_file(file_q.size());
    // Hold the sender until that whole run has come out.
    wait_drained();

    // Directed: a file that ends inside its type header reports an early end.
    put_type_header(tga_pkg::TYPE_RLE);
    send_file(3);

    // Random files until the byte budget is used up; the last stretch runs without idling.
    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      if (bytes_sent > QUIET_AFTER) quiet = 1'b1;
      sender_gaps = ($urandom_range(0, 3) != 0);
      random_file();
      if ($urandom_range(0, 3) == 0) wait_drained();
    end

    @(negedge clk);
    file_bytes.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (error_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: tga_rle_image_decoder_unit.f
sv/tga_pkg.sv
sv/tga_stream_if.sv
sv/tga_dp.sv
sv/tga_ctrl.sv
sv/tga_rle_image_decoder_unit.sv
verif/tga_decode_checker.sv
verif/tga_rle_image_decoder_unit_test.sv
